/* hw/rtl/gps_sentence_framer_checker_core_assert.svh */
// Assertion macros for the sentence framer checker.
// Each check is one clocked property, disabled while the active-low reset is asserted.
`ifndef GPS_SENTENCE_FRAMER_CHECKER_CORE_ASSERT_SVH
`define GPS_SENTENCE_FRAMER_CHECKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define GSFC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication
`define GSFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define GSFC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define GSFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/gsfc_pkg.sv */
package gsfc_pkg;

    // Framing phases
    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_G    = 3'd1;
    localparam logic [2:0] PH_P    = 3'd2;
    localparam logic [2:0] PH_BODY = 3'd3;
    localparam logic [2:0] PH_HEX1 = 3'd4;
    localparam logic [2:0] PH_HEX2 = 3'd5;
    localparam logic [2:0] PH_CR   = 3'd6;
    localparam logic [2:0] PH_LF   = 3'd7;

    // Body length limits
    localparam logic [6:0] MIN_BODY = 7'd5;
    localparam logic [6:0] MAX_BODY = 7'd94;

    // Characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Sentence kinds
    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_GGA   = 3'd1;
    localparam logic [2:0] KIND_GSV   = 3'd2;
    localparam logic [2:0] KIND_GLL   = 3'd3;
    localparam logic [2:0] KIND_TXT   = 3'd4;

    localparam logic [23:0] TAG_GGA = 24'h474741;
    localparam logic [23:0] TAG_GSV = 24'h475356;
    localparam logic [23:0] TAG_GLL = 24'h474C4C;
    localparam logic [23:0] TAG_TXT = 24'h545854;

    typedef struct packed {
        logic        checksum_ok;
        logic [2:0]  sentence_kind;
        logic [6:0]  body_length;
        logic [7:0]  computed_checksum;
        logic [7:0]  received_checksum;
        logic [31:0] sentence_count;
    } t_result;

    typedef struct packed {
        logic       enable;
        logic [2:0] phase;
    } t_frm_status;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [2:0] kind_of(input logic [23:0] letters);
        logic [2:0] k;
        k = KIND_OTHER;
        if (letters == TAG_GGA) k = KIND_GGA;
        else if (letters == TAG_GSV) k = KIND_GSV;
        else if (letters == TAG_GLL) k = KIND_GLL;
        else if (letters == TAG_TXT) k = KIND_TXT;
        return k;
    endfunction

endpackage

/* hw/rtl/gsfc_if.sv */
// Received character channel
interface gsfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// Sentence report channel
interface gsfc_result_if;
    logic        valid;
    logic        ready;
    logic        checksum_ok;
    logic [2:0]  sentence_kind;
    logic [6:0]  body_length;
    logic [7:0]  computed_checksum;
    logic [7:0]  received_checksum;
    logic [31:0] sentence_count;

    modport source (
        output valid, output checksum_ok, output sentence_kind, output body_length,
        output computed_checksum, output received_checksum, output sentence_count,
        input ready
    );
    modport sink (
        input valid, input checksum_ok, input sentence_kind, input body_length,
        input computed_checksum, input received_checksum, input sentence_count,
        output ready
    );
endinterface

/* hw/rtl/gsfc_in_stage.sv */
module gsfc_in_stage
    import gsfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_byte,
    input  logic       i_take
);

    logic       r_valid;
    logic [7:0] r_byte;

    // Accept when empty or when the held character leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    // Hold one character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

/* hw/rtl/gsfc_framer.sv */
module gsfc_framer
    import gsfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_fire,
    input  logic [7:0]  i_byte,
    output logic        o_res_valid,
    output t_result     o_res,
    output t_frm_status o_status
);

    logic        r_enable;
    logic [2:0]  r_phase;
    logic [6:0]  r_body_count;
    logic [7:0]  r_xor;
    logic [7:0]  r_hex;
    logic [23:0] r_letters;
    logic [31:0] r_frames;

    logic        n_enable;
    logic [2:0]  n_phase;
    logic [6:0]  n_body_count;
    logic [7:0]  n_xor;
    logic [7:0]  n_hex;
    logic [23:0] n_letters;
    logic [31:0] n_frames;
    logic        res_valid;
    t_hex        dig;
    logic [31:0] frames_inc;

    assign dig        = hex_digit(i_byte);
    assign frames_inc = r_frames + 32'd1;

    // Advance framing by one character
    always_comb begin
        n_enable     = r_enable;
        n_phase      = r_phase;
        n_body_count = r_body_count;
        n_xor        = r_xor;
        n_hex        = r_hex;
        n_letters    = r_letters;
        n_frames     = r_frames;
        res_valid    = 1'b0;

        if (i_fire) begin
            priority if (!r_enable) begin
                n_frames = '0;
                n_phase  = PH_HUNT;
            end else if (i_byte == CH_DOLLAR) begin
                n_phase      = PH_G;
                n_body_count = '0;
                n_xor        = '0;
                n_hex        = '0;
                n_letters    = '0;
            end else begin
                unique case (r_phase)
                    PH_G, PH_P: begin
                        if (i_byte == ((r_phase == PH_G) ? CH_G : CH_P)) begin
                            n_xor   = r_xor ^ i_byte;
                            n_phase = r_phase + 3'd1;
                        end else begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_BODY: begin
                        priority if (i_byte == CH_STAR) begin
                            n_phase = (r_body_count >= MIN_BODY) ? PH_HEX1 : PH_HUNT;
                        end else if (i_byte == CH_CR || i_byte == CH_LF
                                     || r_body_count >= MAX_BODY) begin
                            n_phase = PH_HUNT;
                        end else begin
                            n_xor = r_xor ^ i_byte;
                            if (r_body_count < 7'd3) begin
                                n_letters = {r_letters[15:0], i_byte};
                            end
                            n_body_count = r_body_count + 7'd1;
                        end
                    end
                    PH_HEX1, PH_HEX2: begin
                        if (!dig.valid) begin
                            n_phase = PH_HUNT;
                        end else begin
                            n_hex   = {r_hex[3:0], dig.value};
                            n_phase = r_phase + 3'd1;
                        end
                    end
                    PH_CR: begin
                        n_phase = (i_byte == CH_CR) ? PH_LF : PH_HUNT;
                    end
                    PH_LF: begin
                        n_phase = PH_HUNT;
                        if (i_byte == CH_LF) begin
                            n_frames  = frames_inc;
                            res_valid = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
            end
        end

        // Register write; disabling drops framing and clears the count
        if (i_cfg_we) begin
            n_enable = i_cfg_wdata;
            if (!i_cfg_wdata) begin
                n_frames = '0;
                n_phase  = PH_HUNT;
            end
        end
    end

    // Build the report from the finished frame
    assign o_res_valid             = res_valid;
    assign o_res.checksum_ok       = (r_xor == r_hex);
    assign o_res.sentence_kind     = kind_of(r_letters);
    assign o_res.body_length       = r_body_count;
    assign o_res.computed_checksum = r_xor;
    assign o_res.received_checksum = r_hex;
    assign o_res.sentence_count    = frames_inc;

    assign o_status.enable = r_enable;
    assign o_status.phase  = r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_phase      <= PH_HUNT;
            r_body_count <= '0;
            r_xor        <= '0;
            r_hex        <= '0;
            r_letters    <= '0;
            r_frames     <= '0;
        end else begin
            r_enable     <= n_enable;
            r_phase      <= n_phase;
            r_body_count <= n_body_count;
            r_xor        <= n_xor;
            r_hex        <= n_hex;
            r_letters    <= n_letters;
            r_frames     <= n_frames;
        end
    end

endmodule

/* hw/rtl/gsfc_out_stage.sv */
module gsfc_out_stage
    import gsfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    take;
    logic    pop;

    // Ready comes from a register only, so the sink's stall does not reach upstream
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign take    = i_valid && o_ready;
    assign pop     = r_main_valid && i_ready;

    // Track occupancy of main and skid entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= take;
            end
        end else if (take) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    // Move payloads
    always_ff @(posedge i_clk) begin
        if (pop && r_skid_valid) begin
            r_main <= r_skid;
        end else if (take && (pop || !r_main_valid)) begin
            r_main <= i_data;
        end
        if (take && r_main_valid && !pop) begin
            r_skid <= i_data;
        end
    end

endmodule

/* hw/rtl/gps_sentence_framer_checker_core.sv */
// GPS sentence framer and checker.
// i_rx carries one received character per transaction (valid/ready). Each
// complete "$GP<body>*hh<CR><LF>" frame yields one transaction on o_res with
// the checksum result, sentence kind, body length, both checksums and the
// running sentence count; all other characters yield nothing.
// i_cfg_we/i_cfg_wdata write parse_enable; write it only while idle.
// Writing 0 returns the framer to hunting for '$' and clears the count.
// Throughput: one character per cycle while the output stage has room. A
// character is held in the input register, then the framer updates its
// state and loads the report into the output register.
// Reset (synchronous, active low) disables parsing, empties both stages and
// clears the framing state and the count.
// When o_res is stalled, the two-entry output stage absorbs one more report;
// i_rx.ready drops only once both entries are full, and no report is lost.
module gps_sentence_framer_checker_core
    import gsfc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    gsfc_byte_if.sink     i_rx,
    gsfc_result_if.source o_res
);

`include "gps_sentence_framer_checker_core_assert.svh"

    logic        in_valid;
    logic [7:0]  in_byte;
    logic        out_ready;
    logic        fire;
    logic        frm_res_valid;
    t_result     frm_res;
    t_frm_status frm_status;
    t_result     res_data;

    // Consume a held character whenever the output stage has room
    assign fire = in_valid && out_ready;

    gsfc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .i_byte  (i_rx.rx_byte),
        .o_ready (i_rx.ready),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .i_take  (out_ready)
    );

    gsfc_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_byte      (in_byte),
        .o_res_valid (frm_res_valid),
        .o_res       (frm_res),
        .o_status    (frm_status)
    );

    gsfc_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (frm_res_valid),
        .i_data  (frm_res),
        .o_ready (out_ready),
        .o_valid (o_res.valid),
        .o_data  (res_data),
        .i_ready (o_res.ready)
    );

    // Drive the report fields
    assign o_res.checksum_ok       = res_data.checksum_ok;
    assign o_res.sentence_kind     = res_data.sentence_kind;
    assign o_res.body_length       = res_data.body_length;
    assign o_res.computed_checksum = res_data.computed_checksum;
    assign o_res.received_checksum = res_data.received_checksum;
    assign o_res.sentence_count    = res_data.sentence_count;

    // Reports only come from an enabled framer
    `GSFC_ASSERT_SAME(a_report_needs_enable, i_clk, i_rst_n, frm_res_valid, frm_status.enable)
    // Reported body length stays within the framing limits
    `GSFC_ASSERT_SAME(a_report_length, i_clk, i_rst_n, frm_res_valid, (frm_res.body_length >= MIN_BODY && frm_res.body_length <= MAX_BODY))
    // Disabling drops back to hunting
    `GSFC_ASSERT_NEXT(a_disable_hunts, i_clk, i_rst_n, (i_cfg_we && !i_cfg_wdata), (frm_status.phase == PH_HUNT && !frm_status.enable))

endmodule
